[sv/clbpw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Character LCD bus master package
// Shared types, codes and the init command table of the busy-poll writer.
// ----------------------------------------------------------------------------
package clbpw_pkg;

  localparam int unsigned INIT_STEPS = 6;
  localparam logic [7:0] BusyBit = 8'h80;
  localparam logic [15:0] PollMax = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_INSTR  = 2'd0,
    CMD_DATA   = 2'd1,
    CMD_STATUS = 2'd2,
    CMD_INIT   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } bus_op_e;

  typedef enum logic [1:0] {
    REG_WRITE_STROBE  = 2'd0,
    REG_READ_STROBE   = 2'd1,
    REG_POWER_ON_WAIT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] value;
  } req_t;

  typedef struct packed {
    bus_op_e     bus_op;
    logic        reg_select;
    logic [7:0]  bus_byte;
    logic [7:0]  strobe_ms;
    logic [7:0]  wait_before_ms;
    logic [15:0] poll_total;
    logic        sequence_done;
    logic        last;
  } rsp_t;

  typedef struct packed {
    cfg_reg_e   index;
    logic [7:0] data;
  } cfg_t;

  typedef struct packed {
    logic [7:0] write_strobe_ms;
    logic [7:0] read_strobe_ms;
    logic [7:0] power_on_wait_ms;
  } cfg_regs_t;

  typedef struct packed {
    logic valid;
    logic two;
    rsp_t first;
    rsp_t second;
  } push_t;

  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] cmd;
    unique case (idx)
      3'd0:    cmd = 8'h38;
      3'd1:    cmd = 8'h08;
      3'd2:    cmd = 8'h01;
      3'd3:    cmd = 8'h06;
      3'd4:    cmd = 8'h0D;
      default: cmd = 8'h02;
    endcase
    return cmd;
  endfunction

endpackage
`default_nettype wire

[sv/clbpw_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Valid/ready channel
// One transfer moves one payload when valid and ready are both high.
// ----------------------------------------------------------------------------
interface clbpw_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[sv/clbpw_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Busy-poll sequencer core
// Holds the pending byte, init step and poll count, and forms the results.
// ----------------------------------------------------------------------------
module clbpw_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  advance_i,
  input  clbpw_pkg::req_t      req_i,
  input  clbpw_pkg::cfg_regs_t cfg_i,
  output clbpw_pkg::push_t     push_o
);

  logic [7:0]  held_byte_q, held_byte_d;
  logic        held_select_q, held_select_d;
  logic        awaiting_q, awaiting_d;
  logic [2:0]  init_index_q, init_index_d;
  logic [15:0] busy_polls_q, busy_polls_d;
  logic [15:0] polls_inc;
  clbpw_pkg::rsp_t reject, rd_res, wr_res;

  always_comb begin
    polls_inc = (busy_polls_q == clbpw_pkg::PollMax) ? busy_polls_q : busy_polls_q + 16'd1;

    reject = '0;
    reject.bus_op = clbpw_pkg::OP_NONE;
    reject.last = 1'b1;

    rd_res = '0;
    rd_res.bus_op = clbpw_pkg::OP_READ;
    rd_res.strobe_ms = cfg_i.read_strobe_ms;
    rd_res.last = 1'b1;

    wr_res = '0;
    wr_res.bus_op = clbpw_pkg::OP_WRITE;
    wr_res.reg_select = held_select_q;
    wr_res.bus_byte = held_byte_q;
    wr_res.strobe_ms = cfg_i.write_strobe_ms;
    wr_res.poll_total = busy_polls_q;

    held_byte_d = held_byte_q;
    held_select_d = held_select_q;
    awaiting_d = awaiting_q;
    init_index_d = init_index_q;
    busy_polls_d = busy_polls_q;

    push_o.valid = advance_i;
    push_o.two = 1'b0;
    push_o.first = reject;
    push_o.second = rd_res;

    if (req_i.command == clbpw_pkg::CMD_STATUS) begin
      if (!awaiting_q) begin
        push_o.first = reject;
      end else if ((req_i.value & clbpw_pkg::BusyBit) != 8'd0) begin
        busy_polls_d = polls_inc;
        push_o.first = rd_res;
        push_o.first.poll_total = polls_inc;
      end else begin
        busy_polls_d = '0;
        if (init_index_q != 3'd0 && init_index_q < 3'(clbpw_pkg::INIT_STEPS)) begin
          push_o.first = wr_res;
          push_o.two = 1'b1;
          held_byte_d = clbpw_pkg::init_cmd(init_index_q);
          held_select_d = 1'b0;
          init_index_d = init_index_q + 3'd1;
        end else begin
          push_o.first = wr_res;
          push_o.first.sequence_done = 1'b1;
          push_o.first.last = 1'b1;
          init_index_d = '0;
          awaiting_d = 1'b0;
        end
      end
    end else if (awaiting_q) begin
      push_o.first = reject;
    end else begin
      awaiting_d = 1'b1;
      busy_polls_d = '0;
      push_o.first = rd_res;
      if (req_i.command == clbpw_pkg::CMD_INIT) begin
        init_index_d = 3'd1;
        held_byte_d = clbpw_pkg::init_cmd(3'd0);
        held_select_d = 1'b0;
        push_o.first.wait_before_ms = cfg_i.power_on_wait_ms;
      end else begin
        init_index_d = '0;
        held_byte_d = req_i.value;
        held_select_d = req_i.command[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_byte_q <= '0;
      held_select_q <= 1'b0;
      awaiting_q <= 1'b0;
      init_index_q <= '0;
      busy_polls_q <= '0;
    end else if (advance_i) begin
      held_byte_q <= held_byte_d;
      held_select_q <= held_select_d;
      awaiting_q <= awaiting_d;
      init_index_q <= init_index_d;
      busy_polls_q <= busy_polls_d;
    end
  end

endmodule
`default_nettype wire

[sv/clbpw_result_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result queue
// Four-entry queue that takes one or two results per push and gives one per
// transfer.
// ----------------------------------------------------------------------------
module clbpw_result_fifo (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  clbpw_pkg::push_t        push_i,
  output logic                    space_o,
  clbpw_stream_if.source          rsp
);

  clbpw_pkg::rsp_t entry_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q, count_d;
  logic       pop;
  logic [2:0] n_push;

  assign space_o = (count_q <= 3'd2);
  assign rsp.valid = (count_q != 3'd0);
  assign rsp.payload = entry_q[rd_ptr_q];
  assign pop = rsp.valid && rsp.ready;
  assign n_push = push_i.valid ? (push_i.two ? 3'd2 : 3'd1) : 3'd0;
  assign count_d = count_q + n_push - {2'b00, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + n_push[1:0];
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      entry_q[wr_ptr_q] <= push_i.first;
      if (push_i.two) begin
        entry_q[wr_ptr_q + 2'd1] <= push_i.second;
      end
    end
  end

endmodule
`default_nettype wire

[sv/char_lcd_busy_poll_writer.sv]
`timescale 1ns / 1ps
`default_nettype none
// A request waits in the request register, and its results in the result queue.
// Throughput: one request per cycle while each gives one result and the queue
// has space; a request that gives a write and the next init read gives two.
// The four-entry result queue lets requests keep flowing while results wait.
// Reset clears all control state and loads the default strobe and wait times.
// ----------------------------------------------------------------------------
// Character LCD busy-poll writer
// Request register, sequencer core, result queue and configuration registers.
// ----------------------------------------------------------------------------
module char_lcd_busy_poll_writer (
  input  wire            clk_i,
  input  wire            rst_ni,
  clbpw_stream_if.sink   cfg,
  clbpw_stream_if.sink   req,
  clbpw_stream_if.source rsp
);

  clbpw_pkg::cfg_regs_t cfg_q;
  clbpw_pkg::req_t      req_q;
  logic                 req_valid_q;
  logic                 space;
  logic                 advance;
  clbpw_pkg::push_t     push;
  clbpw_pkg::cfg_t      cfg_wr;

  assign cfg.ready = 1'b1;
  assign cfg_wr = cfg.payload;
  assign advance = req_valid_q && space;
  assign req.ready = !req_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.write_strobe_ms <= 8'd2;
      cfg_q.read_strobe_ms <= 8'd1;
      cfg_q.power_on_wait_ms <= 8'd50;
    end else if (cfg.valid) begin
      unique case (cfg_wr.index)
        clbpw_pkg::REG_WRITE_STROBE:  cfg_q.write_strobe_ms <= cfg_wr.data;
        clbpw_pkg::REG_READ_STROBE:   cfg_q.read_strobe_ms <= cfg_wr.data;
        clbpw_pkg::REG_POWER_ON_WAIT: cfg_q.power_on_wait_ms <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req.ready) begin
      req_valid_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.ready && req.valid) begin
      req_q <= req.payload;
    end
  end

  clbpw_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .req_i     (req_q),
    .cfg_i     (cfg_q),
    .push_o    (push)
  );

  clbpw_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .rsp     (rsp)
  );

endmodule
`default_nettype wire

[sv/clbpw_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Busy-poll writer port checker
// Checks result stability and the consistency of result fields.
// ----------------------------------------------------------------------------
module clbpw_checker (
  input wire             clk_i,
  input wire             rst_ni,
  input wire             rsp_valid_i,
  input wire             rsp_ready_i,
  input clbpw_pkg::rsp_t rsp_payload_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_payload_i))
    else $error("result changed while stalled");

  a_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_payload_i.bus_op == clbpw_pkg::OP_NONE |->
      rsp_payload_i.last && rsp_payload_i.strobe_ms == 8'd0 &&
      rsp_payload_i.poll_total == 16'd0 && !rsp_payload_i.sequence_done)
    else $error("rejected result carries data");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_payload_i.sequence_done |->
      rsp_payload_i.bus_op == clbpw_pkg::OP_WRITE && rsp_payload_i.last)
    else $error("sequence end on a non-final or non-write result");

  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_ready_i && !rsp_payload_i.last |=>
      rsp_valid_i && rsp_payload_i.bus_op == clbpw_pkg::OP_READ && rsp_payload_i.last)
    else $error("write within init not followed by its status read");

endmodule

bind char_lcd_busy_poll_writer clbpw_checker u_clbpw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp.valid),
  .rsp_ready_i   (rsp.ready),
  .rsp_payload_i (rsp.payload)
);
`default_nettype wire
